/* sv/bep_pkg.sv */
package bep_pkg;

   // Number of bytes in the id field.
   localparam int unsigned ID_BYTES = 16;

   // Field tags.
   localparam logic [4:0] F_VERSION = 5'd0;
   localparam logic [4:0] F_ID      = 5'd1;
   localparam logic [4:0] F_PRIO    = 5'd2;
   localparam logic [4:0] F_STATUS  = 5'd3;
   localparam logic [4:0] F_COPIES  = 5'd4;
   localparam logic [4:0] F_MAXCOPY = 5'd5;
   localparam logic [4:0] F_HOPS    = 5'd6;
   localparam logic [4:0] F_CREATED = 5'd7;
   localparam logic [4:0] F_EXPIRY  = 5'd8;
   localparam logic [4:0] F_SLEN0   = 5'd9;
   localparam logic [4:0] F_SLEN1   = 5'd11;
   localparam logic [4:0] F_SLEN2   = 5'd13;
   localparam logic [4:0] F_SLEN3   = 5'd15;
   localparam logic [4:0] F_PLEN    = 5'd17;
   localparam logic [4:0] F_PAYLOAD = 5'd18;
   localparam logic [4:0] F_TRAIL   = 5'd19;

   // Verdict codes.
   localparam logic [2:0] V_OK        = 3'd0;
   localparam logic [2:0] V_VERSION   = 3'd1;
   localparam logic [2:0] V_TRUNCATED = 3'd2;
   localparam logic [2:0] V_PRIORITY  = 3'd3;
   localparam logic [2:0] V_STATUS    = 3'd4;
   localparam logic [2:0] V_PAYLOAD   = 3'd5;

   // Range limits for the checked header bytes.
   localparam logic [31:0] MAX_PRIORITY = 32'd3;
   localparam logic [7:0]  MAX_STATUS   = 8'd4;

   // Configuration register indexes and reset values.
   localparam logic CSR_EXPECTED_VERSION = 1'b0;
   localparam logic CSR_MAX_PAYLOAD_LEN  = 1'b1;
   localparam logic [7:0]  VERSION_RESET     = 8'd1;
   localparam logic [30:0] MAX_PAYLOAD_RESET = 31'(16 * 1024 * 1024);

   // Saturation value of the byte index.
   localparam logic [30:0] IDX_MAX = 31'h7FFF_FFFF;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [4:0]  field_tag;
      logic [7:0]  byte_value;
      logic [30:0] index_in_field;
      logic        verdict_valid;
      logic [2:0]  verdict;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  expected_version;
      logic [30:0] max_payload_len;
   } cfg_type;

endpackage

/* sv/bep_csr.sv */
module bep_csr
   import bep_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic        csr_index,
   input  logic [30:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff;

   // Registers are written whenever a write arrives; the port never stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_version <= VERSION_RESET;
         cfg_ff.max_payload_len  <= MAX_PAYLOAD_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_EXPECTED_VERSION: cfg_ff.expected_version <= csr_wdata[7:0];
            CSR_MAX_PAYLOAD_LEN:  cfg_ff.max_payload_len  <= csr_wdata;
            default:              cfg_ff                  <= cfg_ff;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

/* sv/bep_parse.sv */
module bep_parse
   import bep_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   logic [4:0]  field_ff, field_in;
   logic [30:0] count_ff, count_in;
   logic [31:0] length_ff, length_in;
   logic [2:0]  error_ff, error_in;

   logic [7:0]  b;
   logic [31:0] idx_inc;
   logic        done;
   logic [2:0]  cand;
   logic [31:0] cap_base;
   logic [31:0] cap_value;
   logic        plen_bad;
   logic [2:0]  verdict;

   assign b       = item.data_byte;
   assign idx_inc = {1'b0, count_ff} + 32'd1;

   // Little-endian assembly of a length field, restarted on its first byte.
   assign cap_base  = (count_ff == 31'd0) ? 32'd0 : length_ff;
   assign cap_value = cap_base | ({24'd0, b} << {count_ff[1:0], 3'b000});

   // Per-field work: checks, length capture and end of field.
   always_comb begin
      done      = 1'b0;
      cand      = V_OK;
      length_in = length_ff;
      unique case (field_ff)
         F_VERSION: begin
            if (b != cfg.expected_version) begin
               cand = V_VERSION;
            end
            done = 1'b1;
         end
         F_ID: begin
            done = idx_inc >= 32'(ID_BYTES);
         end
         F_PRIO: begin
            length_in = {24'd0, b};
            done      = 1'b1;
         end
         F_STATUS: begin
            if (length_ff > MAX_PRIORITY) begin
               cand = V_PRIORITY;
            end else if (b > MAX_STATUS) begin
               cand = V_STATUS;
            end
            done = 1'b1;
         end
         F_COPIES, F_MAXCOPY, F_HOPS: begin
            done = idx_inc >= 32'd4;
         end
         F_CREATED, F_EXPIRY: begin
            done = idx_inc >= 32'd8;
         end
         F_SLEN0, F_SLEN1, F_SLEN2, F_SLEN3: begin
            length_in = cap_value;
            done      = idx_inc >= 32'd2;
         end
         F_PLEN: begin
            length_in = cap_value;
            done      = idx_inc >= 32'd4;
         end
         F_TRAIL: begin
            done = 1'b0;
         end
         default: begin
            // String bodies and the payload run for the captured length.
            done = idx_inc >= length_ff;
         end
      endcase
   end

   assign plen_bad = length_in[31] || (length_in[30:0] > cfg.max_payload_len);

   // Next field, byte index and first error.
   always_comb begin
      field_in = field_ff;
      count_in = count_ff;
      error_in = error_ff;
      if ((error_ff == V_OK) && (cand != V_OK)) begin
         error_in = cand;
      end
      if (done) begin
         count_in = 31'd0;
         field_in = field_ff + 5'd1;
         if (field_ff == F_PLEN) begin
            if (plen_bad) begin
               if (error_ff == V_OK) begin
                  error_in = V_PAYLOAD;
               end
               field_in = F_TRAIL;
            end else if (length_in == 32'd0) begin
               field_in = F_TRAIL;
            end else begin
               field_in = F_PAYLOAD;
            end
         end else if ((field_ff == F_SLEN0) || (field_ff == F_SLEN1) ||
                      (field_ff == F_SLEN2) || (field_ff == F_SLEN3)) begin
            if (length_in == 32'd0) begin
               field_in = field_ff + 5'd2;
            end
         end
      end else if (field_ff != F_TRAIL) begin
         count_in = idx_inc[30:0];
      end else if (count_ff != IDX_MAX) begin
         count_in = idx_inc[30:0];
      end
   end

   // Verdict on the last byte of a message.
   always_comb begin
      verdict = V_OK;
      if (item.end_of_message) begin
         verdict = error_in;
         if ((error_in == V_OK) && (field_in != F_TRAIL)) begin
            verdict = V_TRUNCATED;
         end
      end
   end

   assign result.field_tag      = field_ff;
   assign result.byte_value     = b;
   assign result.index_in_field = count_ff;
   assign result.verdict_valid  = item.end_of_message;
   assign result.verdict        = verdict;

   // Parse state advances once per item and restarts after each message.
   always_ff @(posedge clock) begin
      if (reset) begin
         field_ff  <= F_VERSION;
         count_ff  <= 31'd0;
         length_ff <= 32'd0;
         error_ff  <= V_OK;
      end else if (advance) begin
         if (item.end_of_message) begin
            field_ff  <= F_VERSION;
            count_ff  <= 31'd0;
            length_ff <= 32'd0;
            error_ff  <= V_OK;
         end else begin
            field_ff  <= field_in;
            count_ff  <= count_in;
            length_ff <= length_in;
            error_ff  <= error_in;
         end
      end
   end

endmodule

/* sv/bundle_envelope_parser_core.sv */
// Streaming envelope parser, one byte per item.
// Input channel req_*: one envelope byte and a last-byte flag per item,
// accepted when req_valid is high and req_stall is low.
// Result channel rsp_*: one item per input byte with its field tag, the
// byte, its index inside the field and, on the last byte, the verdict.
// Each item passes through the input register and then the result register,
// and rsp_valid is high while the result register is full. There is one
// input register and one result register, with the parse logic between them.
// Throughput is one item per cycle while rsp_stall is low; the parse state
// (field, index, captured length, first error) is updated once per item.
// When the receiver holds rsp_stall, the result register keeps its item, the
// input register takes one more item only if empty, and req_stall then rises.
// Configuration writes on csr_* are always taken (csr_ready is high) and
// must only be made while the block is idle.
// A synchronous reset empties both registers, returns the parser to the
// version field and loads the register reset values.
module bundle_envelope_parser_core
   import bep_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_item,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_item,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [30:0] csr_wdata
);

   cfg_type cfg;
   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_item_ff;
   rsp_type result;
   logic    move_out;
   logic    advance;

   bep_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bep_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // Flow control between the input register and the result register.
   assign move_out    = !out_valid_ff || !rsp_stall;
   assign advance     = in_valid_ff && move_out;
   assign req_stall   = in_valid_ff && !move_out;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;
   assign out_valid_in = move_out ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers load only on a transfer.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_item_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;
   assign csr_ready = 1'b1;

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import bep_pkg::*;

   // Row of the directed stimulus table; expected fields are used only when listed is set.
   typedef struct {
      logic [7:0]  data_byte;
      logic        eom;
      bit          listed;
      logic [4:0]  tag;
      logic [30:0] idx;
      logic [2:0]  verdict;
   } probe_row_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_item = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_item;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_EXPECTED_VERSION;
   logic [30:0] csr_wdata = '0;

   // Parser state as predicted by the testbench.
   logic [4:0]  st_field;
   logic [30:0] st_idx;
   logic [31:0] st_len;
   logic [2:0]  st_err;
   logic [7:0]  cfg_version;
   logic [30:0] cfg_max_len;

   rsp_type       tagged_bytes_due[$];
   logic [7:0]    env_bytes[$];
   probe_row_type probe_rows[$];
   int          mismatch_count = 0;
   int          rsp_seen = 0;
   int          sent_count = 0;
   bit          idle_on = 1'b1;
   bit          long_hold = 1'b0;

   bundle_envelope_parser_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Hard limit on the run time.
   initial begin
      #5_000_000;
      $display("bundle_envelope_parser_core test failed");
      $finish;
   end

   task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
      mismatch_count++;
      if (mismatch_count <= 50) begin
         $display("mismatch at result %0d: %s got %0d, expected %0d",
                  rsp_seen, what, got, want);
      end
   endtask

   function automatic void note_error(logic [2:0] code);
      if (st_err == V_OK) begin
         st_err = code;
      end
   endfunction

   // Advances the predicted parser by one byte and returns the result it must produce.
   function automatic rsp_type parse_byte(logic [7:0] b, logic eom);
      rsp_type     r;
      logic [4:0]  f;
      logic [4:0]  nxt;
      logic [31:0] idx_next;
      logic        done;
      f = st_field;
      idx_next = {1'b0, st_idx} + 32'd1;
      done = 1'b0;
      r.field_tag = f;
      r.byte_value = b;
      r.index_in_field = st_idx;
      unique case (f)
         F_VERSION: begin
            if (b != cfg_version) note_error(V_VERSION);
            done = 1'b1;
         end
         F_ID: begin
            done = idx_next >= ID_BYTES;
         end
         F_PRIO: begin
            st_len = {24'd0, b};
            done = 1'b1;
         end
         F_STATUS: begin
            // Priority is judged first, from the byte captured one step earlier.
            if (st_len > MAX_PRIORITY) note_error(V_PRIORITY);
            else if (b > MAX_STATUS) note_error(V_STATUS);
            done = 1'b1;
         end
         F_COPIES, F_MAXCOPY, F_HOPS: begin
            done = idx_next >= 32'd4;
         end
         F_CREATED, F_EXPIRY: begin
            done = idx_next >= 32'd8;
         end
         F_SLEN0, F_SLEN1, F_SLEN2, F_SLEN3, F_PLEN: begin
            if (st_idx == '0) st_len = '0;
            st_len = st_len | (32'(b) << (8 * st_idx[1:0]));
            done = idx_next >= ((f == F_PLEN) ? 32'd4 : 32'd2);
         end
         F_TRAIL: begin
            if (st_idx < IDX_MAX) st_idx = st_idx + 31'd1;
         end
         default: begin
            // String bodies and payload.
            done = idx_next >= st_len;
         end
      endcase

      if (done) begin
         st_idx = '0;
         nxt = f + 5'd1;
         if (f == F_PLEN) begin
            if (st_len[31] || st_len > {1'b0, cfg_max_len}) begin
               note_error(V_PAYLOAD);
               nxt = F_TRAIL;
            end else if (st_len == '0) begin
               nxt = F_TRAIL;
            end else begin
               nxt = F_PAYLOAD;
            end
         end else if ((f == F_SLEN0 || f == F_SLEN1 || f == F_SLEN2 || f == F_SLEN3)
                      && st_len == '0) begin
            // Empty string: skip its body.
            nxt = f + 5'd2;
         end
         st_field = nxt;
      end else if (f != F_TRAIL) begin
         st_idx = idx_next[30:0];
      end

      if (eom) begin
         r.verdict_valid = 1'b1;
         r.verdict = (st_err == V_OK && st_field != F_TRAIL) ? V_TRUNCATED : st_err;
         st_field = F_VERSION;
         st_idx = '0;
         st_len = '0;
         st_err = V_OK;
      end else begin
         r.verdict_valid = 1'b0;
         r.verdict = V_OK;
      end
      return r;
   endfunction

   // Offers one item, waits for it to be taken and records what it must produce.
   // Called and returns at a falling edge.
   task automatic send_byte(logic [7:0] b, logic eom, bit listed, rsp_type listed_rsp);
      rsp_type want;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item <= '{data_byte: b, end_of_message: eom};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      want = parse_byte(b, eom);
      if (listed) want = listed_rsp;
      tagged_bytes_due.push_back(want);
      sent_count++;
      @(negedge clock);
   endtask

   // Stops offering items until every pending result has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (tagged_bytes_due.size() != 0);
   endtask

   task automatic write_config(logic [7:0] ver, logic [30:0] max_len);
      csr_valid <= 1'b1;
      for (int i = 0; i < 2; i++) begin
         csr_index <= (i == 0) ? CSR_EXPECTED_VERSION : CSR_MAX_PAYLOAD_LEN;
         csr_wdata <= (i == 0) ? 31'(ver) : max_len;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
      cfg_version = ver;
      cfg_max_len = max_len;
   endtask

   function automatic void put_le(logic [63:0] v, int n);
      for (int k = 0; k < n; k++) begin
         env_bytes.push_back(v[8*k +: 8]);
      end
   endfunction

   // Builds one envelope, mostly well formed, sometimes with bad checked fields or cut short.
   function automatic void build_envelope();
      int          sel;
      int          slen;
      logic [31:0] plen;
      env_bytes.delete();
      env_bytes.push_back(($urandom_range(0, 9) != 0) ? cfg_version : 8'($urandom));
      repeat (ID_BYTES) env_bytes.push_back(8'($urandom));
      env_bytes.push_back(($urandom_range(0, 6) != 0) ? 8'($urandom_range(0, 3))
                                                      : 8'($urandom_range(4, 255)));
      env_bytes.push_back(($urandom_range(0, 6) != 0) ? 8'($urandom_range(0, 4))
                                                      : 8'($urandom_range(5, 255)));
      repeat (3) put_le(64'($urandom), 4);
      repeat (2) put_le({$urandom, $urandom}, 8);
      repeat (4) begin
         sel = $urandom_range(0, 39);
         if (sel < 16) slen = 0;
         else if (sel < 39) slen = $urandom_range(1, 6);
         else slen = $urandom_range(250, 300);
         put_le(64'(slen), 2);
         repeat (slen) env_bytes.push_back(8'($urandom));
      end

      sel = $urandom_range(0, 9);
      if (sel < 3) plen = '0;
      else if (sel < 7) plen = $urandom_range(1, 12);
      else if (sel == 7) plen = (cfg_max_len <= 64) ? {1'b0, cfg_max_len}
                                                    : 32'($urandom_range(13, 40));
      else if (sel == 8) plen = {1'b0, cfg_max_len} + 32'd1;
      else plen = $urandom | 32'h8000_0000;
      put_le(64'(plen), 4);
      if (!plen[31] && plen <= {1'b0, cfg_max_len}) begin
         repeat (plen) env_bytes.push_back(8'($urandom));
      end
      repeat ($urandom_range(0, 4)) env_bytes.push_back(8'($urandom));

      // Some envelopes end early, a few exactly on the priority byte.
      sel = $urandom_range(0, 19);
      if (sel == 0) env_bytes = env_bytes[0:ID_BYTES + 1];
      else if (sel < 4) env_bytes = env_bytes[0:$urandom_range(0, env_bytes.size() - 2)];
   endfunction

   task automatic send_envelope();
      build_envelope();
      foreach (env_bytes[i]) begin
         send_byte(env_bytes[i], i == env_bytes.size() - 1, 1'b0, '0);
      end
   endtask

   // Short run of random bytes with random end flags.
   task automatic send_noise();
      repeat ($urandom_range(1, 8)) begin
         send_byte(8'($urandom), $urandom_range(0, 3) == 0, 1'b0, '0);
      end
   endtask

   // Result side: random stall bursts, plus one long hold-off on request.
   initial begin
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (40) @(negedge clock);
            long_hold = 1'b0;
            rsp_stall <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare each accepted result with the oldest pending one.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (tagged_bytes_due.size() == 0) begin
            flag_mismatch("result with nothing pending, byte", rsp_item.byte_value, 0);
         end else begin
            want = tagged_bytes_due.pop_front();
            if (rsp_item.field_tag !== want.field_tag)
               flag_mismatch("field_tag", rsp_item.field_tag, want.field_tag);
            if (rsp_item.byte_value !== want.byte_value)
               flag_mismatch("byte_value", rsp_item.byte_value, want.byte_value);
            if (rsp_item.index_in_field !== want.index_in_field)
               flag_mismatch("index_in_field", rsp_item.index_in_field, want.index_in_field);
            if (rsp_item.verdict_valid !== want.verdict_valid)
               flag_mismatch("verdict_valid", rsp_item.verdict_valid, want.verdict_valid);
            if (rsp_item.verdict !== want.verdict)
               flag_mismatch("verdict", rsp_item.verdict, want.verdict);
         end
      end
   end

   initial begin
      rsp_type listed_rsp;
      int      phase_start;
      bit      poked;

      st_field = F_VERSION;
      st_idx = '0;
      st_len = '0;
      st_err = V_OK;
      cfg_version = VERSION_RESET;
      cfg_max_len = MAX_PAYLOAD_RESET;

      // Directed table: single-byte messages, a header with bad priority and status, a cut one.
      probe_rows.push_back('{8'h00, 1'b1, 1'b1, F_VERSION, 31'd0, V_VERSION});
      probe_rows.push_back('{8'hFF, 1'b1, 1'b1, F_VERSION, 31'd0, V_VERSION});
      probe_rows.push_back('{8'h01, 1'b1, 1'b1, F_VERSION, 31'd0, V_TRUNCATED});
      probe_rows.push_back('{8'h01, 1'b0, 1'b1, F_VERSION, 31'd0, V_OK});
      for (int i = 0; i < ID_BYTES; i++) begin
         probe_rows.push_back('{8'(i * 17), 1'b0, 1'b0, F_ID, 31'd0, V_OK});
      end
      probe_rows.push_back('{8'h04, 1'b0, 1'b0, F_PRIO, 31'd0, V_OK});
      probe_rows.push_back('{8'h05, 1'b1, 1'b1, F_STATUS, 31'd0, V_PRIORITY});
      probe_rows.push_back('{8'h01, 1'b0, 1'b0, F_VERSION, 31'd0, V_OK});
      probe_rows.push_back('{8'h00, 1'b1, 1'b1, F_ID, 31'd0, V_TRUNCATED});

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      foreach (probe_rows[i]) begin
         listed_rsp = '{field_tag: probe_rows[i].tag, byte_value: probe_rows[i].data_byte,
                        index_in_field: probe_rows[i].idx,
                        verdict_valid: probe_rows[i].eom, verdict: probe_rows[i].verdict};
         send_byte(probe_rows[i].data_byte, probe_rows[i].eom, probe_rows[i].listed,
                   listed_rsp);
      end

      // Random phases, each under its own register setting.
      for (int ph = 0; ph < 5; ph++) begin
         if (ph > 0) begin
            wait_drained();
            repeat (4) @(negedge clock);
            unique case (ph)
               1: write_config(8'h00, 31'd0);
               2: write_config(8'hFF, 31'h7FFF_FFFF);
               3: write_config(8'($urandom_range(0, 255)), 31'($urandom_range(1, 40)));
               default: write_config(8'($urandom_range(0, 255)), 31'd16);
            endcase
         end
         if (ph == 4) idle_on = 1'b0;
         phase_start = sent_count;
         poked = 1'b0;
         while (sent_count - phase_start < 370) begin
            if (!poked && sent_count - phase_start >= 100) begin
               poked = 1'b1;
               if (ph == 2) long_hold = 1'b1;
               if (ph == 3) wait_drained();
            end
            if ($urandom_range(0, 4) != 0) send_envelope();
            else send_noise();
         end
      end

      req_valid <= 1'b0;
      for (int w = 0; w < 2000 && tagged_bytes_due.size() != 0; w++) @(negedge clock);
      repeat (8) @(negedge clock);
      if (tagged_bytes_due.size() != 0) begin
         flag_mismatch("results never arrived, count", tagged_bytes_due.size(), 0);
      end

      if (mismatch_count == 0) begin
         $display("bundle_envelope_parser_core test passed");
      end else begin
         $display("bundle_envelope_parser_core test failed");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/bep_pkg.sv
sv/bep_csr.sv
sv/bep_parse.sv
sv/bundle_envelope_parser_core.sv
tb/sv/testbench.sv
